[rtl/core/nssd_pkg.sv]
// Shared types, constants and the digit-to-segment lookup for the seven-segment number encoder.
`default_nettype none

package nssd_pkg;

  // Default build values for the top-level parameters.
  localparam int unsigned NSSD_MAX_DIGITS = 8;
  localparam int unsigned NSSD_ROWS       = 10;

  // Fixed field widths.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned START_W = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned MAG_W   = 27;

  // The binary-to-decimal conversion is cut into this many register stages.
  localparam int unsigned DABBLE_STAGES = 4;
  localparam int unsigned DABBLE_STEPS  = 7;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_BLANK  = 2'd1,
    KIND_SIGNED = 2'd2
  } nssd_kind_e;

  // Per-item control fields that travel with the conversion data.
  typedef struct packed {
    nssd_kind_e         kind;
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] start;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   keep;
    logic               neg;
  } nssd_ctl_t;

  function automatic logic [SEG_W-1:0] seg_lut(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[rtl/core/nssd_front.sv]
// Input register: takes a command, normalizes its fields and drops items that show nothing.
`default_nettype none

module nssd_front
  import nssd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = NSSD_MAX_DIGITS,
  parameter int unsigned ROWS       = NSSD_ROWS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    ready_o,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [ROW_W-1:0]   row_i,
  input  wire logic [START_W-1:0] start_req_i,
  input  wire logic [CNT_W-1:0]   digit_count_i,
  input  wire logic [CNT_W-1:0]   keep_i,
  input  wire logic [MAG_W-1:0]   magnitude_i,
  input  wire logic               negative_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output nssd_ctl_t               ctl_o,
  output logic [MAG_W-1:0]        bin_o
);

  logic      valid_q, valid_d;
  nssd_ctl_t ctl_q, ctl_d;
  logic      row_ok;
  logic      has_cells;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ctl_d.row   = row_i;
    ctl_d.start = start_req_i;
    ctl_d.keep  = keep_i;
    ctl_d.neg   = negative_i;
    ctl_d.count = (digit_count_i > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count_i;
    case (kind_i)
      KIND_BLANK:  ctl_d.kind = KIND_BLANK;
      KIND_SIGNED: ctl_d.kind = KIND_SIGNED;
      default:     ctl_d.kind = KIND_PLAIN;
    endcase
  end

  // Rows outside the display and digit-only items with no digits make no cells.
  assign row_ok    = {1'b0, row_i} < (ROW_W + 1)'(ROWS);
  assign has_cells = (ctl_d.kind == KIND_SIGNED) || (ctl_d.count != '0);
  assign valid_d   = start_i && row_ok && has_cells;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_d) begin
      ctl_q <= ctl_d;
      bin_o <= magnitude_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

[rtl/core/nssd_dabble_stage.sv]
// One register stage of the shift-and-add-3 binary-to-decimal conversion.
`default_nettype none

module nssd_dabble_stage
  import nssd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = NSSD_MAX_DIGITS,
  parameter int unsigned STEPS      = DABBLE_STEPS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire nssd_ctl_t               ctl_i,
  input  wire logic [MAG_W-1:0]        bin_i,
  input  wire logic [4*MAX_DIGITS-1:0] bcd_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output nssd_ctl_t                    ctl_o,
  output logic [MAG_W-1:0]             bin_o,
  output logic [4*MAX_DIGITS-1:0]      bcd_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;

  logic                   valid_q;
  logic [BCD_W+MAG_W-1:0] acc;

  assign ready_o = !valid_q || ready_i;

  // Each step corrects every digit that would overflow on doubling, then shifts one bit in.
  // Digits above the top one are dropped, which keeps the value modulo ten to the digit count.
  always_comb begin
    acc = {bcd_i, bin_i};
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (acc[MAG_W+4*d +: 4] >= 4'd5) begin
          acc[MAG_W+4*d +: 4] = acc[MAG_W+4*d +: 4] + 4'd3;
        end
      end
      acc = acc << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_o <= ctl_i;
      bin_o <= acc[MAG_W-1:0];
      bcd_o <= acc[BCD_W+MAG_W-1:MAG_W];
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/core/nssd_cell_emit.sv]
// Cell sequencer: walks the sign cell and the digits of one item, one cell code per cycle.
`default_nettype none

module nssd_cell_emit
  import nssd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = NSSD_MAX_DIGITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire nssd_ctl_t               ctl_i,
  input  wire logic [4*MAX_DIGITS-1:0] bcd_i,
  output logic                         valid_o,
  output logic [ROW_W-1:0]             out_row_o,
  output logic [POS_W-1:0]             position_o,
  output logic [SEG_W-1:0]             segments_o,
  output logic                         last_o
);

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic             active_q;
  logic [CNT_W-1:0] cell_q;
  logic             seen_q;
  nssd_ctl_t        ctl_q;
  logic [3:0]       dig_q [MAX_DIGITS];

  logic             signed_item;
  logic             is_sign;
  logic [CNT_W-1:0] n_cells;
  logic [CNT_W-1:0] dig_off;
  logic [CNT_W-1:0] dig_sel;
  logic [3:0]       digit;
  logic             seen_now;
  logic             blank;
  logic             last;
  logic             load;

  assign signed_item = (ctl_q.kind == KIND_SIGNED);
  assign n_cells     = ctl_q.count + CNT_W'(signed_item);
  assign is_sign     = signed_item && (cell_q == '0);
  assign dig_off     = cell_q - CNT_W'(signed_item);
  // Digits go out most significant first.
  assign dig_sel     = ctl_q.count - CNT_W'(1) - dig_off;
  assign digit       = dig_q[dig_sel[IDX_W-1:0]];
  assign seen_now    = seen_q || (digit != 4'd0);
  assign blank       = (ctl_q.kind == KIND_BLANK) && !seen_now && (dig_off < ctl_q.keep);
  assign last        = (cell_q + CNT_W'(1)) == n_cells;

  always_comb begin
    if (is_sign) begin
      segments_o = ctl_q.neg ? SEG_MINUS : SEG_BLANK;
    end else if (blank) begin
      segments_o = SEG_BLANK;
    end else begin
      segments_o = seg_lut(digit);
    end
  end

  // A new item is taken while the final cell of the current one goes out.
  assign ready_o = !active_q || last;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cell_q   <= '0;
      seen_q   <= 1'b0;
    end else if (load) begin
      active_q <= 1'b1;
      cell_q   <= '0;
      seen_q   <= 1'b0;
    end else if (active_q) begin
      if (last) begin
        active_q <= 1'b0;
      end
      cell_q <= cell_q + CNT_W'(1);
      if (!is_sign) begin
        seen_q <= seen_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q <= ctl_i;
      for (int d = 0; d < MAX_DIGITS; d++) begin
        dig_q[d] <= bcd_i[4*d +: 4];
      end
    end
  end

  assign valid_o    = active_q;
  assign out_row_o  = ctl_q.row;
  assign position_o = POS_W'(ctl_q.start) + POS_W'(cell_q);
  assign last_o     = last;

endmodule

`default_nettype wire

[rtl/core/number_to_seven_segment_digits.sv]
// Top level of the seven-segment number encoder: input register, conversion pipeline, sequencer.
//
//   Channel   Direction  Handshake                  Payload
//   command   in         start / busy               kind_i row_i start_req_i digit_count_i
//                                                   keep_i magnitude_i negative_i
//   cell      out        valid_o strobe, no stall   out_row_o position_o segments_o last_o
//
// A command transfer happens at a rising edge where start is high and busy is low. The
// item is registered, then converted to decimal in four shift-and-add-3 stages and loaded
// into the sequencer, whose register puts out its first cell. The cell sequencer gives one
// cell per cycle, so an item occupies it for one to nine cells (digit count, plus one
// for the sign cell); that sequencer sets the sustained rate. Up to five more items wait
// in the pipeline meanwhile, and busy rises only when all of them are full.
// Items whose row is off the display, or that would show no cell, leave no trace.
// The asynchronous active-low reset empties the pipeline; no cell is lost or repeated on a
// stall, and the cell receiver never stalls.
`default_nettype none

module number_to_seven_segment_digits
  import nssd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = NSSD_MAX_DIGITS,
  parameter int unsigned ROWS       = NSSD_ROWS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [KIND_W-1:0]  kind_i,
  input  wire logic [ROW_W-1:0]   row_i,
  input  wire logic [START_W-1:0] start_req_i,
  input  wire logic [CNT_W-1:0]   digit_count_i,
  input  wire logic [CNT_W-1:0]   keep_i,
  input  wire logic [MAG_W-1:0]   magnitude_i,
  input  wire logic               negative_i,
  output logic                    valid_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [POS_W-1:0]        position_o,
  output logic [SEG_W-1:0]        segments_o,
  output logic                    last_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;
  localparam int unsigned LAST  = DABBLE_STAGES - 1;

  // Index s feeds conversion stage s; index DABBLE_STAGES feeds the sequencer.
  logic             vld [DABBLE_STAGES+1];
  logic             rdy [DABBLE_STAGES+1];
  nssd_ctl_t        ctl [DABBLE_STAGES+1];
  logic [BCD_W-1:0] bcd [DABBLE_STAGES+1];
  logic [MAG_W-1:0] bin [DABBLE_STAGES];
  logic             front_ready;

  assign busy   = !front_ready;
  assign bcd[0] = '0;

  nssd_front #(
    .MAX_DIGITS(MAX_DIGITS),
    .ROWS      (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .ready_o      (front_ready),
    .kind_i       (kind_i),
    .row_i        (row_i),
    .start_req_i  (start_req_i),
    .digit_count_i(digit_count_i),
    .keep_i       (keep_i),
    .magnitude_i  (magnitude_i),
    .negative_i   (negative_i),
    .valid_o      (vld[0]),
    .ready_i      (rdy[0]),
    .ctl_o        (ctl[0]),
    .bin_o        (bin[0])
  );

  // The last stage takes whatever steps remain of the magnitude width.
  for (genvar s = 0; s < DABBLE_STAGES; s++) begin : g_dabble
    if (s == LAST) begin : g_tail
      nssd_dabble_stage #(
        .MAX_DIGITS(MAX_DIGITS),
        .STEPS     (MAG_W - DABBLE_STEPS * LAST)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(vld[s]),
        .ready_o(rdy[s]),
        .ctl_i  (ctl[s]),
        .bin_i  (bin[s]),
        .bcd_i  (bcd[s]),
        .valid_o(vld[s+1]),
        .ready_i(rdy[s+1]),
        .ctl_o  (ctl[s+1]),
        .bin_o  (),
        .bcd_o  (bcd[s+1])
      );
    end else begin : g_body
      nssd_dabble_stage #(
        .MAX_DIGITS(MAX_DIGITS),
        .STEPS     (DABBLE_STEPS)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(vld[s]),
        .ready_o(rdy[s]),
        .ctl_i  (ctl[s]),
        .bin_i  (bin[s]),
        .bcd_i  (bcd[s]),
        .valid_o(vld[s+1]),
        .ready_i(rdy[s+1]),
        .ctl_o  (ctl[s+1]),
        .bin_o  (bin[s+1]),
        .bcd_o  (bcd[s+1])
      );
    end
  end

  nssd_cell_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vld[DABBLE_STAGES]),
    .ready_o   (rdy[DABBLE_STAGES]),
    .ctl_i     (ctl[DABBLE_STAGES]),
    .bcd_i     (bcd[DABBLE_STAGES]),
    .valid_o   (valid_o),
    .out_row_o (out_row_o),
    .position_o(position_o),
    .segments_o(segments_o),
    .last_o    (last_o)
  );

endmodule

`default_nettype wire

[test/number_to_seven_segment_digits_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the seven-segment number encoder: directed rows, then random numbers.

module number_to_seven_segment_digits_tb;
  import nssd_pkg::*;

  // The kind field is two bits wide, but the package names only three codes. The fourth
  // code is legal on the port and must behave exactly like plain digits.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 325;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned DRAIN_EVERY   = 120;
  // Pipeline depth plus a full sequencer run, with margin, so that a late cell still shows.
  localparam int unsigned TAIL_CYCLES   = 24;
  // A directed row with this cell count is checked against the predictor.
  localparam int          USE_PREDICTOR = -1;

  // Common-cathode codes for decimal digits 9 down to 0, digit 0 in the low byte.
  localparam logic [10*SEG_W-1:0] DIGIT_SEGS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  // One number to be shown, as it crosses the command transfer.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] start;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   keep;
    logic [MAG_W-1:0]   mag;
    logic               neg;
  } digit_cmd_t;

  // One display cell written by the block.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [POS_W-1:0] pos;
    logic [SEG_W-1:0] seg;
    logic             last;
  } cell_t;

  // A directed row either names its outcome directly (no cell, or one cell with a known
  // code) or leaves the outcome to the predictor.
  typedef struct {
    digit_cmd_t       cmd;
    int               typed_cells;
    logic [SEG_W-1:0] typed_seg;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  kind_i = '0;
  logic [ROW_W-1:0]   row_i = '0;
  logic [START_W-1:0] start_req_i = '0;
  logic [CNT_W-1:0]   digit_count_i = '0;
  logic [CNT_W-1:0]   keep_i = '0;
  logic [MAG_W-1:0]   magnitude_i = '0;
  logic               negative_i = 1'b0;
  logic               valid_o;
  logic [ROW_W-1:0]   out_row_o;
  logic [POS_W-1:0]   position_o;
  logic [SEG_W-1:0]   segments_o;
  logic               last_o;

  // Cells still owed by the block, oldest first.
  cell_t         cells_due[$];
  directed_row_t directed_rows[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cells_seen = 0;
  int unsigned   cycle_count = 0;

  number_to_seven_segment_digits uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .row_i        (row_i),
    .start_req_i  (start_req_i),
    .digit_count_i(digit_count_i),
    .keep_i       (keep_i),
    .magnitude_i  (magnitude_i),
    .negative_i   (negative_i),
    .valid_o      (valid_o),
    .out_row_o    (out_row_o),
    .position_o   (position_o),
    .segments_o   (segments_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost cell ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at cycle %0d, cell %0d: %s", cycle_count, cells_seen, what);
  endtask

  // Works out the cells for one accepted number and queues them. Off-display rows write
  // nothing. The digit count saturates at the maximum, higher decimal digits fall away, the
  // spare kind acts as plain digits, and the sign cell shifts the digits right by one.
  function automatic void predict_cells(input digit_cmd_t c);
    int unsigned      dec[NSSD_MAX_DIGITS];
    int unsigned      value;
    int unsigned      shown;
    int unsigned      offset;
    int unsigned      d;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0] pos;
    bit               seen_nonzero;
    cell_t            entry;

    if (c.row >= NSSD_ROWS) return;
    shown = (c.count > NSSD_MAX_DIGITS) ? NSSD_MAX_DIGITS : c.count;
    kind = (c.kind == KIND_SPARE) ? KIND_PLAIN : c.kind;
    value = 32'(c.mag);
    for (int j = 0; j < NSSD_MAX_DIGITS; j++) begin
      dec[j] = value % 10;
      value = value / 10;
    end

    entry.row = c.row;
    pos = POS_W'(c.start);
    if (kind == KIND_SIGNED) begin
      // The sign cell carries the minus bar even for a zero magnitude.
      entry.pos = pos;
      entry.seg = c.neg ? SEG_MINUS : SEG_BLANK;
      entry.last = (shown == 0);
      cells_due.push_back(entry);
      pos = pos + 1'b1;
    end

    // Most significant digit first; blanking stops at the first nonzero digit.
    seen_nonzero = 1'b0;
    for (offset = 0; offset < shown; offset++) begin
      d = dec[shown - 1 - offset];
      if (d != 0) seen_nonzero = 1'b1;
      entry.seg = DIGIT_SEGS[d*SEG_W +: SEG_W];
      if (kind == KIND_BLANK && !seen_nonzero && offset < c.keep) entry.seg = SEG_BLANK;
      entry.pos = pos + POS_W'(offset);
      entry.last = (offset + 1 == shown);
      cells_due.push_back(entry);
    end
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input int unsigned row,
                         input int unsigned first, input int unsigned count,
                         input int unsigned keep, input int unsigned mag, input bit neg,
                         input int typed_cells, input logic [SEG_W-1:0] typed_seg);
    directed_row_t r;
    r.cmd.kind = kind;
    r.cmd.row = row[ROW_W-1:0];
    r.cmd.start = first[START_W-1:0];
    r.cmd.count = count[CNT_W-1:0];
    r.cmd.keep = keep[CNT_W-1:0];
    r.cmd.mag = mag[MAG_W-1:0];
    r.cmd.neg = neg;
    r.typed_cells = typed_cells;
    r.typed_seg = typed_seg;
    directed_rows.push_back(r);
  endtask

  // Presents one number after an idle gap and holds it until the transfer completes. The
  // start strobe stays high when the gap is zero, so back-to-back transfers happen without a
  // bubble. Busy is read right after the edge, so it is the value the block saw there.
  task automatic send_number(input digit_cmd_t c, input int unsigned gap,
                             input int typed_cells, input logic [SEG_W-1:0] typed_seg);
    cell_t entry;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= c.kind;
    row_i <= c.row;
    start_req_i <= c.start;
    digit_count_i <= c.count;
    keep_i <= c.keep;
    magnitude_i <= c.mag;
    negative_i <= c.neg;
    do @(posedge clk_i); while (busy);
    if (typed_cells == USE_PREDICTOR) begin
      predict_cells(c);
    end else if (typed_cells == 1) begin
      entry.row = c.row;
      entry.pos = POS_W'(c.start);
      entry.seg = typed_seg;
      entry.last = 1'b1;
      cells_due.push_back(entry);
    end
  endtask

  // Stops sending and waits for every owed cell. At least one edge passes, so start is
  // never lowered and raised again in the same time step.
  task automatic drain_cells();
    start <= 1'b0;
    @(posedge clk_i);
    while (cells_due.size() != 0) @(posedge clk_i);
  endtask

  // Cell checker. The receiver cannot stall, so every cycle with valid high is one transfer.
  always @(posedge clk_i) begin : check_cells
    cell_t want;
    if (rst_ni && valid_o) begin
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("unexpected cell row %0d pos %0d seg %02h last %0b",
                                  out_row_o, position_o, segments_o, last_o));
      end else begin
        want = cells_due.pop_front();
        if (out_row_o !== want.row)
          report_mismatch($sformatf("row %0d, want %0d", out_row_o, want.row));
        if (position_o !== want.pos)
          report_mismatch($sformatf("position %0d, want %0d", position_o, want.pos));
        if (segments_o !== want.seg)
          report_mismatch($sformatf("segments %02h, want %02h", segments_o, want.seg));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
      cells_seen++;
    end
  end

  initial begin : stimulus
    digit_cmd_t  c;
    int unsigned on_display;
    int unsigned sent;
    bit          steady;
    bit          noise;
    int          exponent;

    // Directed rows: kind, row, start, count, keep, magnitude, negative, outcome.
    add_row(KIND_PLAIN, 0, 0, 8, 0, 99999999, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_PLAIN, 9, 7, 8, 0, 12345678, 1, USE_PREDICTOR, SEG_BLANK);
    // Rows off the display and empty fields write nothing at all.
    add_row(KIND_PLAIN, 15, 3, 4, 0, 1234, 0, 0, SEG_BLANK);
    add_row(KIND_SIGNED, 10, 0, 4, 0, 1234, 1, 0, SEG_BLANK);
    add_row(KIND_PLAIN, 2, 1, 0, 0, 55, 0, 0, SEG_BLANK);
    add_row(KIND_BLANK, 3, 2, 0, 8, 0, 0, 0, SEG_BLANK);
    // A signed field with no digits is just the sign cell, marked last.
    add_row(KIND_SIGNED, 4, 5, 0, 0, 0, 1, 1, SEG_MINUS);
    add_row(KIND_SIGNED, 5, 6, 0, 0, 77, 0, 1, SEG_BLANK);
    add_row(KIND_PLAIN, 6, 7, 1, 0, 9, 0, 1, 8'h6F);
    add_row(KIND_BLANK, 7, 0, 1, 1, 0, 0, 1, SEG_BLANK);
    add_row(KIND_SPARE, 8, 4, 1, 1, 7, 0, 1, 8'h07);
    // Oversized count saturates; the top decimal digits of the magnitude fall away.
    add_row(KIND_PLAIN, 1, 0, 15, 0, 27'h7FFFFFF, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 2, 0, 8, 8, 0, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 3, 0, 8, 15, 0, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 4, 0, 8, 0, 0, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 5, 1, 6, 4, 1020, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 6, 0, 8, 3, 507, 0, USE_PREDICTOR, SEG_BLANK);
    // Highest position: sign at 7, last digit at 15.
    add_row(KIND_SIGNED, 7, 7, 8, 0, 99999999, 1, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_SIGNED, 8, 2, 5, 0, 0, 1, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_SIGNED, 9, 3, 3, 0, 123456, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_PLAIN, 0, 5, 9, 0, 100000000, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_PLAIN, 1, 6, 4, 0, 0, 0, USE_PREDICTOR, SEG_BLANK);
    // The spare kind ignores keep, just as plain digits do.
    add_row(KIND_SPARE, 2, 0, 8, 8, 10, 1, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_SIGNED, 3, 0, 8, 15, 0, 0, USE_PREDICTOR, SEG_BLANK);
    add_row(KIND_BLANK, 4, 0, 15, 15, 5, 1, USE_PREDICTOR, SEG_BLANK);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_number(directed_rows[i].cmd, $urandom_range(0, MAX_GAP),
                  directed_rows[i].typed_cells, directed_rows[i].typed_seg);
    drain_cells();

    // Random numbers. Most are well formed; about one in ten is noise that may fall off the
    // display, carry the spare kind, or ask for zero or too many digits. Only numbers on the
    // display count toward the total. The sender switches now and then into a steady run
    // with no idle cycles, so the pipeline also fills and busy gets exercised.
    on_display = 0;
    sent = 0;
    steady = 1'b0;
    while (on_display < RANDOM_ITEMS) begin
      noise = ($urandom_range(0, 9) == 0);
      c.kind = noise ? KIND_W'($urandom_range(0, 3)) : KIND_W'($urandom_range(0, 2));
      c.row = noise ? ROW_W'($urandom_range(0, 15)) : ROW_W'($urandom_range(0, NSSD_ROWS - 1));
      c.start = START_W'($urandom_range(0, 7));
      c.count = noise ? CNT_W'($urandom_range(0, 15))
                      : CNT_W'($urandom_range(1, NSSD_MAX_DIGITS));
      c.keep = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 15))
                                             : CNT_W'($urandom_range(0, NSSD_MAX_DIGITS));
      exponent = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: c.mag = MAG_W'($urandom);
        1: c.mag = MAG_W'($urandom_range(0, 99999999));
        2: c.mag = MAG_W'($urandom_range(0, 10 ** exponent));
        default: c.mag = MAG_W'($urandom_range(0, 9) * (10 ** exponent));
      endcase
      c.neg = 1'($urandom_range(0, 1));

      if ($urandom_range(0, 39) == 0) steady = !steady;
      send_number(c, steady ? 0 : $urandom_range(0, MAX_GAP), USE_PREDICTOR, SEG_BLANK);
      if (c.row < NSSD_ROWS) on_display++;
      sent++;
      if (sent % DRAIN_EVERY == 0) drain_cells();
    end

    drain_cells();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
